[hdl/midi_initial_channel_state_capture_core_defines.svh]
// Assertion macros for the MIDI initial channel state capture core.
// Used by the checker; no other dependencies.
`ifndef MIDI_INITIAL_CHANNEL_STATE_CAPTURE_CORE_DEFINES_SVH
`define MIDI_INITIAL_CHANNEL_STATE_CAPTURE_CORE_DEFINES_SVH

// same-cycle implication, masked during reset
`define MICSC_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("micsc: assertion failed");

// next-cycle implication, masked during reset
`define MICSC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("micsc: assertion failed");

// implication that is also checked around reset
`define MICSC_ASSERT_RAW(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |-> (cons)) \
    else $error("micsc: assertion failed");

`endif

[hdl/micsc_pkg.sv]
// Shared types and constants for the MIDI initial channel state capture core.
// No dependencies.
package micsc_pkg;

  localparam int DEF_CHANNELS = 16;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [3:0] KIND_CTRL = 4'hB;
  localparam logic [3:0] KIND_PROG = 4'hC;
  localparam logic [3:0] KIND_BEND = 4'hE;

  localparam logic [6:0] CC_VOLUME     = 7'd7;
  localparam logic [6:0] CC_PAN        = 7'd10;
  localparam logic [6:0] CC_EXPRESSION = 7'd11;

  localparam logic [13:0] BEND_CENTER = 14'd8192;

  localparam logic OP_CLEAR = 1'b1;

  localparam logic [1:0] REG_DEF_VOLUME     = 2'd0;
  localparam logic [1:0] REG_DEF_PAN        = 2'd1;
  localparam logic [1:0] REG_DEF_EXPRESSION = 2'd2;

  localparam logic [6:0] RST_DEF_VOLUME     = 7'd100;
  localparam logic [6:0] RST_DEF_PAN        = 7'd64;
  localparam logic [6:0] RST_DEF_EXPRESSION = 7'd127;

  localparam int FLAG_PROGRAM    = 0;
  localparam int FLAG_VOLUME     = 1;
  localparam int FLAG_PAN        = 2;
  localparam int FLAG_EXPRESSION = 3;
  localparam int FLAG_BEND       = 4;

  typedef struct packed {
    logic        clear;
    logic [3:0]  chan;
    logic        wr_prog;
    logic        wr_vol;
    logic        wr_pan;
    logic        wr_expr;
    logic        wr_bend;
    logic [6:0]  d1;
    logic [6:0]  d2;
    logic [13:0] bend;
  } cmd_t;

  typedef struct packed {
    logic [3:0]         chan;
    logic [6:0]         prog;
    logic [6:0]         vol;
    logic [6:0]         pan;
    logic [6:0]         expr;
    logic signed [13:0] bend;
    logic [4:0]         mask;
  } res_t;

endpackage

[hdl/micsc_fifo.sv]
// Small synchronous request queue with registered storage.
// Depends on micsc_pkg for the default depth.
module micsc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = micsc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

[hdl/micsc_front.sv]
// Front end: classifies an incoming MIDI request into a capture command.
// Depends on micsc_pkg.
module micsc_front (
  input  logic             op,
  input  logic             at_start,
  input  logic [7:0]       status_byte,
  input  logic [6:0]       data_first,
  input  logic [6:0]       data_second,
  output micsc_pkg::cmd_t  cmd
);
  import micsc_pkg::*;

  logic [3:0] kind;
  logic       live;

  assign kind = status_byte[7:4];
  assign live = (op != OP_CLEAR) & at_start;

  always_comb begin
    cmd         = '0;
    cmd.clear   = (op == OP_CLEAR);
    cmd.chan    = status_byte[3:0];
    cmd.d1      = data_first;
    cmd.d2      = data_second;
    cmd.bend    = {data_second, data_first} - BEND_CENTER;
    if (live) begin
      unique case (kind)
        KIND_PROG: cmd.wr_prog = 1'b1;
        KIND_BEND: cmd.wr_bend = 1'b1;
        KIND_CTRL: begin
          cmd.wr_vol  = (data_first == CC_VOLUME);
          cmd.wr_pan  = (data_first == CC_PAN);
          cmd.wr_expr = (data_first == CC_EXPRESSION);
        end
        default: ;
      endcase
    end
  end

endmodule

[hdl/micsc_back.sv]
// Back end: per-channel capture state, first-value update and result build.
// Also holds the default-value registers. Depends on micsc_pkg.
module micsc_back #(
  parameter int CHANNELS = micsc_pkg::DEF_CHANNELS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [6:0]       cfg_data,
  input  micsc_pkg::cmd_t  cmd,
  input  logic             cmd_avail,
  output logic             cmd_take,
  output micsc_pkg::res_t  res,
  input  logic             res_full,
  output logic             res_push
);
  import micsc_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [4:0]  flags_r [CHANNELS];
  logic [6:0]  prog_r  [CHANNELS];
  logic [6:0]  vol_r   [CHANNELS];
  logic [6:0]  pan_r   [CHANNELS];
  logic [6:0]  expr_r  [CHANNELS];
  logic [13:0] bend_r  [CHANNELS];

  logic [6:0] def_vol_r, def_pan_r, def_expr_r;

  logic [CH_W-1:0] idx;
  logic            ch_ok;
  logic            fire;
  logic [4:0]      f_cur, f_new;
  logic            take_prog, take_vol, take_pan, take_expr, take_bend;

  assign idx      = cmd.chan[CH_W-1:0];
  assign ch_ok    = ({1'b0, cmd.chan} < 5'(CHANNELS));
  assign fire     = cmd_avail & ~res_full;
  assign cmd_take = fire;
  assign res_push = fire;

  always_comb begin
    f_cur     = flags_r[idx];
    take_prog = ch_ok & cmd.wr_prog & ~f_cur[FLAG_PROGRAM];
    take_vol  = ch_ok & cmd.wr_vol  & ~f_cur[FLAG_VOLUME];
    take_pan  = ch_ok & cmd.wr_pan  & ~f_cur[FLAG_PAN];
    take_expr = ch_ok & cmd.wr_expr & ~f_cur[FLAG_EXPRESSION];
    take_bend = ch_ok & cmd.wr_bend & ~f_cur[FLAG_BEND];
    f_new     = f_cur | {take_bend, take_expr, take_pan, take_vol, take_prog};

    res      = '0;
    res.chan = cmd.chan;
    res.vol  = def_vol_r;
    res.pan  = def_pan_r;
    res.expr = def_expr_r;
    if (!cmd.clear && ch_ok) begin
      res.mask = f_new;
      if (take_prog)                 res.prog = cmd.d1;
      else if (f_cur[FLAG_PROGRAM])  res.prog = prog_r[idx];
      if (take_vol)                  res.vol  = cmd.d2;
      else if (f_cur[FLAG_VOLUME])   res.vol  = vol_r[idx];
      if (take_pan)                  res.pan  = cmd.d2;
      else if (f_cur[FLAG_PAN])      res.pan  = pan_r[idx];
      if (take_expr)                 res.expr = cmd.d2;
      else if (f_cur[FLAG_EXPRESSION]) res.expr = expr_r[idx];
      if (take_bend)                 res.bend = $signed(cmd.bend);
      else if (f_cur[FLAG_BEND])     res.bend = $signed(bend_r[idx]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        flags_r[i] <= '0;
      end
    end else if (fire) begin
      if (cmd.clear) begin
        for (int i = 0; i < CHANNELS; i++) begin
          flags_r[i] <= '0;
        end
      end else if (ch_ok) begin
        flags_r[idx] <= f_new;
      end
    end
  end

  // value stores: meaningful only where the matching flag is set
  always_ff @(posedge clk) begin
    if (fire && !cmd.clear) begin
      if (take_prog) prog_r[idx] <= cmd.d1;
      if (take_vol)  vol_r[idx]  <= cmd.d2;
      if (take_pan)  pan_r[idx]  <= cmd.d2;
      if (take_expr) expr_r[idx] <= cmd.d2;
      if (take_bend) bend_r[idx] <= cmd.bend;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_vol_r  <= RST_DEF_VOLUME;
      def_pan_r  <= RST_DEF_PAN;
      def_expr_r <= RST_DEF_EXPRESSION;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEF_VOLUME:     def_vol_r  <= cfg_data;
        REG_DEF_PAN:        def_pan_r  <= cfg_data;
        REG_DEF_EXPRESSION: def_expr_r <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[hdl/midi_initial_channel_state_capture_core.sv]
// Throughput: one request per cycle while the result queue has room; each
// event request does one read-modify-write of its channel entry in the back
// end, with a 2-entry queue on each side.
// Reset (rst_n low, synchronous): queues empty, all found flags cleared,
// defaults 100/64/127; value stores are not reset and need no clearing pass.
module midi_initial_channel_state_capture_core #(
  parameter int CHANNELS = micsc_pkg::DEF_CHANNELS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_op,
  input  logic               in_at_start,
  input  logic [7:0]         in_status_byte,
  input  logic [6:0]         in_data_first,
  input  logic [6:0]         in_data_second,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [3:0]         out_channel,
  output logic [6:0]         out_program_res,
  output logic [6:0]         out_volume,
  output logic [6:0]         out_pan,
  output logic [6:0]         out_expression,
  output logic signed [13:0] out_pitch_bend,
  output logic [4:0]         out_found_mask
);
  import micsc_pkg::*;

  cmd_t cmd_in, cmd_q;
  res_t res_d, res_q;
  logic cmd_empty, cmd_take, res_full, res_push;

  micsc_front u_front (
    .op          (in_op),
    .at_start    (in_at_start),
    .status_byte (in_status_byte),
    .data_first  (in_data_first),
    .data_second (in_data_second),
    .cmd         (cmd_in)
  );

  micsc_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (cmd_in),
    .full  (in_full),
    .pop   (cmd_take),
    .dout  (cmd_q),
    .empty (cmd_empty)
  );

  micsc_back #(.CHANNELS(CHANNELS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_q),
    .cmd_avail (~cmd_empty),
    .cmd_take  (cmd_take),
    .res       (res_d),
    .res_full  (res_full),
    .res_push  (res_push)
  );

  micsc_fifo #(.WIDTH($bits(res_t)), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_d),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_q),
    .empty (out_empty)
  );

  assign out_channel     = res_q.chan;
  assign out_program_res = res_q.prog;
  assign out_volume      = res_q.vol;
  assign out_pan         = res_q.pan;
  assign out_expression  = res_q.expr;
  assign out_pitch_bend  = res_q.bend;
  assign out_found_mask  = res_q.mask;

endmodule

[hdl/micsc_checker.sv]
// Port-level checker for the MIDI initial channel state capture core, with bind.
// Depends on midi_initial_channel_state_capture_core_defines.svh.
`include "midi_initial_channel_state_capture_core_defines.svh"

module micsc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_push,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input logic [3:0]         out_channel,
  input logic [6:0]         out_program_res,
  input logic signed [13:0] out_pitch_bend,
  input logic [4:0]         out_found_mask
);

  `MICSC_ASSERT_RAW(a_reset_empty, clk, rst_n && $past(!rst_n), out_empty)

  `MICSC_ASSERT_NEXT(a_head_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_channel) && $stable(out_pitch_bend) && $stable(out_found_mask))

  `MICSC_ASSERT_NOW(a_push_lands, clk, rst_n, in_push && !in_full, ##2 !out_empty)

  `MICSC_ASSERT_NOW(a_unfound_zero, clk, rst_n, !out_empty, (out_found_mask[0] || out_program_res == 7'd0) && (out_found_mask[4] || out_pitch_bend == 14'sd0))

endmodule

bind midi_initial_channel_state_capture_core micsc_checker u_micsc_checker (.*);

[dv/tb_midi_initial_channel_state_capture_core.sv]
// Testbench for midi_initial_channel_state_capture_core: directed and random MIDI events,
// a scoreboard that predicts the per-channel captured state, random stalls on both sides.
// Depends on micsc_pkg (hdl/micsc_pkg.sv) and the core RTL.
module tb_midi_initial_channel_state_capture_core;
  import micsc_pkg::*;

  localparam int NCH = DEF_CHANNELS;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic OP_EVENT = ~OP_CLEAR;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic [3:0] KIND_DATA = 4'h0;
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON = 4'h9;
  localparam logic [3:0] KIND_POLY = 4'hA;
  localparam logic [3:0] KIND_AFTERTOUCH = 4'hD;
  localparam logic [3:0] KIND_SYSTEM = 4'hF;
  localparam logic [6:0] CC_MODWHEEL = 7'd1;

  class capture_scoreboard;
    logic [6:0]  def_volume, def_pan, def_expr;
    logic [6:0]  prog_mem[NCH];
    logic [6:0]  vol_mem[NCH];
    logic [6:0]  pan_mem[NCH];
    logic [6:0]  expr_mem[NCH];
    logic [13:0] bend_mem[NCH];
    logic [4:0]  flags[NCH];
    res_t        expected_reports[$];
    int          mismatches;

    function new();
      def_volume = RST_DEF_VOLUME;
      def_pan    = RST_DEF_PAN;
      def_expr   = RST_DEF_EXPRESSION;
      mismatches = 0;
      clear_all();
    endfunction

    function void clear_all();
      for (int c = 0; c < NCH; c++) begin
        prog_mem[c] = '0;
        vol_mem[c]  = def_volume;
        pan_mem[c]  = def_pan;
        expr_mem[c] = def_expr;
        bend_mem[c] = '0;
        flags[c]    = '0;
      end
    endfunction

    function void set_default(logic [1:0] idx, logic [6:0] val);
      case (idx)
        REG_DEF_VOLUME:     def_volume = val;
        REG_DEF_PAN:        def_pan = val;
        REG_DEF_EXPRESSION: def_expr = val;
        default: ;
      endcase
    endfunction

    function void note_event(logic op, logic at_start, logic [7:0] status,
                             logic [6:0] d1, logic [6:0] d2);
      logic [3:0] ch;
      logic [4:0] f;
      res_t r;
      ch = status[3:0];
      if (op == OP_CLEAR) begin
        clear_all();
      end else if (at_start && ch < NCH) begin
        f = flags[ch];
        case (status[7:4])
          KIND_PROG: begin
            if (!f[FLAG_PROGRAM]) begin
              prog_mem[ch] = d1;
              f[FLAG_PROGRAM] = 1'b1;
            end
          end
          KIND_CTRL: begin
            if (d1 == CC_VOLUME && !f[FLAG_VOLUME]) begin
              vol_mem[ch] = d2;
              f[FLAG_VOLUME] = 1'b1;
            end else if (d1 == CC_PAN && !f[FLAG_PAN]) begin
              pan_mem[ch] = d2;
              f[FLAG_PAN] = 1'b1;
            end else if (d1 == CC_EXPRESSION && !f[FLAG_EXPRESSION]) begin
              expr_mem[ch] = d2;
              f[FLAG_EXPRESSION] = 1'b1;
            end
          end
          KIND_BEND: begin
            if (!f[FLAG_BEND]) begin
              bend_mem[ch] = {d2, d1} - BEND_CENTER;
              f[FLAG_BEND] = 1'b1;
            end
          end
          default: ;
        endcase
        flags[ch] = f;
      end
      r.chan = ch;
      if (ch < NCH) begin
        f = flags[ch];
        r.prog = f[FLAG_PROGRAM] ? prog_mem[ch] : 7'd0;
        r.vol  = f[FLAG_VOLUME] ? vol_mem[ch] : def_volume;
        r.pan  = f[FLAG_PAN] ? pan_mem[ch] : def_pan;
        r.expr = f[FLAG_EXPRESSION] ? expr_mem[ch] : def_expr;
        r.bend = f[FLAG_BEND] ? bend_mem[ch] : 14'd0;
        r.mask = f;
      end else begin
        r.prog = '0;
        r.vol  = def_volume;
        r.pan  = def_pan;
        r.expr = def_expr;
        r.bend = '0;
        r.mask = '0;
      end
      expected_reports.push_back(r);
    endfunction

    function void check_report(res_t got);
      res_t want;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result for channel %0d", got.chan);
        return;
      end
      want = expected_reports.pop_front();
      if (got.chan !== want.chan || got.prog !== want.prog || got.vol !== want.vol ||
          got.pan !== want.pan || got.expr !== want.expr || got.bend !== want.bend ||
          got.mask !== want.mask) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp: ch %0d prog %0d vol %0d pan %0d expr %0d bend %0d mask %b",
                   want.chan, want.prog, want.vol, want.pan, want.expr, want.bend, want.mask);
          $display("         got: ch %0d prog %0d vol %0d pan %0d expr %0d bend %0d mask %b",
                   got.chan, got.prog, got.vol, got.pan, got.expr, got.bend, got.mask);
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [6:0]         cfg_data;
  logic               in_push;
  logic               in_full;
  logic               in_op;
  logic               in_at_start;
  logic [7:0]         in_status_byte;
  logic [6:0]         in_data_first;
  logic [6:0]         in_data_second;
  logic               out_empty;
  logic               out_pop;
  logic [3:0]         out_channel;
  logic [6:0]         out_program_res;
  logic [6:0]         out_volume;
  logic [6:0]         out_pan;
  logic [6:0]         out_expression;
  logic signed [13:0] out_pitch_bend;
  logic [4:0]         out_found_mask;

  capture_scoreboard board;
  int  cycle_count = 0;
  int  rx_hold = 0;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;

  midi_initial_channel_state_capture_core uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_push(in_push), .in_full(in_full), .in_op(in_op), .in_at_start(in_at_start),
    .in_status_byte(in_status_byte), .in_data_first(in_data_first),
    .in_data_second(in_data_second),
    .out_empty(out_empty), .out_pop(out_pop), .out_channel(out_channel),
    .out_program_res(out_program_res), .out_volume(out_volume), .out_pan(out_pan),
    .out_expression(out_expression), .out_pitch_bend(out_pitch_bend),
    .out_found_mask(out_found_mask)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_midi_initial_channel_state_capture_core: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full)
        board.note_event(in_op, in_at_start, in_status_byte, in_data_first, in_data_second);
      if (out_pop && !out_empty)
        board.check_report({out_channel, out_program_res, out_volume, out_pan,
                            out_expression, out_pitch_bend, out_found_mask});
    end
  end

  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // receiver: random pop gaps, plus a long hold-off when requested
  initial begin
    int gap;
    int hold;
    out_pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_hold > 0) begin
        hold = rx_hold;
        rx_hold = 0;
        out_pop <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      gap = rx_steady ? 0 : pick_gap();
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
    end
  end

  task automatic send_event(logic op, logic at_start, logic [7:0] status,
                            logic [6:0] d1, logic [6:0] d2);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push        <= 1'b1;
    in_op          <= op;
    in_at_start    <= at_start;
    in_status_byte <= status;
    in_data_first  <= d1;
    in_data_second <= d2;
    do @(posedge clk); while (in_full);
  endtask

  task automatic send_random_event();
    logic       op;
    logic       at_start;
    logic [3:0] kind;
    logic [3:0] ch;
    logic [6:0] d1;
    logic [6:0] d2;
    int unsigned roll;
    op = ($urandom_range(99) < 3) ? OP_CLEAR : OP_EVENT;
    at_start = ($urandom_range(99) < 85);
    ch = $urandom_range(1) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
    roll = $urandom_range(99);
    if (roll < 30) kind = KIND_CTRL;
    else if (roll < 50) kind = KIND_PROG;
    else if (roll < 70) kind = KIND_BEND;
    else kind = 4'($urandom_range(15));
    d1 = 7'($urandom_range(127));
    if (kind == KIND_CTRL && $urandom_range(99) < 70) begin
      case ($urandom_range(2))
        0: d1 = CC_VOLUME;
        1: d1 = CC_PAN;
        default: d1 = CC_EXPRESSION;
      endcase
    end
    roll = $urandom_range(99);
    if (roll < 5) d2 = 7'd0;
    else if (roll < 10) d2 = 7'd127;
    else d2 = 7'($urandom_range(127));
    send_event(op, at_start, {kind, ch}, d1, d2);
  endtask

  task automatic write_default(logic [1:0] idx, logic [6:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    board.set_default(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (board.expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [6:0] vol, pan, expr;
    board = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_push = 1'b0;
    in_op = OP_EVENT;
    in_at_start = 1'b0;
    in_status_byte = '0;
    in_data_first = '0;
    in_data_second = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_event(OP_EVENT, 1'b0, {KIND_PROG, 4'd0}, 7'd9, 7'd0);
    send_event(OP_EVENT, 1'b1, {KIND_PROG, 4'd0}, 7'd127, 7'd127);
    send_event(OP_EVENT, 1'b1, {KIND_PROG, 4'd0}, 7'd5, 7'd0);
    send_event(OP_EVENT, 1'b1, {KIND_CTRL, 4'd15}, CC_VOLUME, 7'd0);
    send_event(OP_EVENT, 1'b1, {KIND_CTRL, 4'd15}, CC_PAN, 7'd127);
    send_event(OP_EVENT, 1'b1, {KIND_CTRL, 4'd15}, CC_EXPRESSION, 7'd55);
    send_event(OP_EVENT, 1'b1, {KIND_CTRL, 4'd15}, CC_VOLUME, 7'd99);
    send_event(OP_EVENT, 1'b1, {KIND_CTRL, 4'd3}, CC_MODWHEEL, 7'd127);
    send_event(OP_EVENT, 1'b1, {KIND_CTRL, 4'd3}, 7'd127, 7'd0);
    send_event(OP_EVENT, 1'b1, {KIND_BEND, 4'd7}, 7'd0, 7'd0);
    send_event(OP_EVENT, 1'b1, {KIND_BEND, 4'd8}, 7'd127, 7'd127);
    send_event(OP_EVENT, 1'b1, {KIND_BEND, 4'd9}, 7'd0, 7'd64);
    send_event(OP_EVENT, 1'b1, {KIND_BEND, 4'd7}, 7'd127, 7'd127);
    send_event(OP_EVENT, 1'b0, {KIND_BEND, 4'd2}, 7'd1, 7'd1);
    send_event(OP_EVENT, 1'b1, {KIND_NOTE_ON, 4'd1}, 7'd60, 7'd100);
    send_event(OP_EVENT, 1'b1, {KIND_DATA, 4'd5}, 7'd127, 7'd127);
    send_event(OP_EVENT, 1'b1, {KIND_SYSTEM, 4'd15}, 7'd127, 7'd127);
    send_event(OP_EVENT, 1'b1, {KIND_POLY, 4'd4}, 7'd1, 7'd2);
    send_event(OP_EVENT, 1'b1, {KIND_AFTERTOUCH, 4'd4}, 7'd3, 7'd0);
    send_event(OP_EVENT, 1'b1, {KIND_NOTE_OFF, 4'd4}, 7'd0, 7'd0);
    send_event(OP_CLEAR, 1'b1, {KIND_PROG, 4'd0}, 7'd1, 7'd1);
    send_event(OP_CLEAR, 1'b0, {KIND_SYSTEM, 4'd15}, 7'd127, 7'd127);
    send_event(OP_EVENT, 1'b1, {KIND_PROG, 4'd0}, 7'd0, 7'd0);
    send_event(OP_EVENT, 1'b1, {KIND_CTRL, 4'd15}, CC_VOLUME, 7'd127);
    send_event(OP_EVENT, 1'b1, {KIND_BEND, 4'd15}, 7'd127, 7'd0);
    settle();

    // defaults change between phases; captured values must survive them
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin vol = 7'd0; pan = 7'd0; expr = 7'd0; end
        1: begin vol = 7'd127; pan = 7'd127; expr = 7'd127; end
        3: begin vol = RST_DEF_VOLUME; pan = RST_DEF_PAN; expr = RST_DEF_EXPRESSION; end
        default: begin
          vol = 7'($urandom_range(127));
          pan = 7'($urandom_range(127));
          expr = 7'($urandom_range(127));
        end
      endcase
      write_default(REG_DEF_VOLUME, vol);
      write_default(REG_DEF_PAN, pan);
      write_default(REG_DEF_EXPRESSION, expr);
      if (phase == 2) write_default(REG_UNUSED, 7'($urandom_range(127)));
      tx_steady = ($urandom_range(3) == 0);
      rx_steady = ($urandom_range(3) == 0);
      if (phase == 2) begin
        tx_steady = 1'b1;
        rx_hold = 300;
      end
      repeat (250) send_random_event();
      settle();
    end

    if (board.mismatches == 0 && board.expected_reports.size() == 0) begin
      $display("tb_midi_initial_channel_state_capture_core: PASS");
    end else begin
      $display("tb_midi_initial_channel_state_capture_core: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/micsc_pkg.sv
hdl/micsc_fifo.sv
hdl/micsc_front.sv
hdl/micsc_back.sv
hdl/midi_initial_channel_state_capture_core.sv
hdl/micsc_checker.sv
dv/tb_midi_initial_channel_state_capture_core.sv
